[rtl/ctcgd_pkg.sv]
package ctcgd_pkg;

    localparam int SCORE_W     = 16;
    localparam int CLASS_W     = 15;
    localparam int POS_W       = 16;
    localparam int COUNT_W     = 9;
    localparam int TOTAL_W     = 24;
    localparam int DIV_CNT_W   = 5;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 64;

    localparam int MAX_CLASSES = 32768;
    localparam int MAX_STEPS   = 256;

    // Field positions in m_tdata
    localparam int TOKEN_LSB   = 0;
    localparam int TSCORE_LSB  = TOKEN_LSB + CLASS_W;
    localparam int CONF_LSB    = TSCORE_LSB + SCORE_W;
    localparam int CNT_LSB     = CONF_LSB + SCORE_W;
    localparam int ACC_BIT     = CNT_LSB + COUNT_W;
    localparam int M_USED_W    = ACC_BIT + 1;

    // Register indexes on the config channel
    localparam logic REG_DICT_SIZE = 1'b0;
    localparam logic REG_MIN_CONF  = 1'b1;

    localparam logic [CLASS_W-1:0] DICT_SIZE_RST = 15'd32767;
    localparam logic [SCORE_W-1:0] MIN_CONF_RST  = 16'd4096;

    // Output kinds
    localparam logic KIND_TOKEN   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Sequencer states
    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_LOAD    = 2'd1;
    localparam logic [1:0] ST_DIV     = 2'd2;
    localparam logic [1:0] ST_VERDICT = 2'd3;

endpackage

[rtl/ctc_greedy_token_decoder.sv]
// Channel   Dir  Fields (tdata lsb up / tlast / tuser)
// --------  ---  ---------------------------------------------------------------
// s_        in   score[15:0] / last_class / last_step
// m_        out  token, token_score, confidence, emitted_count, accepted, 0-pad
//                / last / kind
// cfg_      in   index 0 = dict_size, 1 = min_confidence; data in cfg_data
//
// One class score is taken per cycle while idle with the output free; argmax and CTC collapse use one compare.
// A timestep end that closes the sequence stalls the input through the load state,
// the bit-serial restoring divider and the verdict state (the divide is skipped
// when nothing was emitted; the verdict waits longer while m_tready is low).
// aresetn is synchronous, active low; it clears all sequence state and
// restores the config registers to their reset values.
// s_tready is low while the output register holds an untaken transaction.
module ctc_greedy_token_decoder
    import ctcgd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // score[15:0]
    input  logic                 s_tlast,   // last_class
    input  logic                 s_tuser,   // last_step

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // token[14:0], token_score[30:15],
                                            // confidence[46:31],
                                            // emitted_count[55:47], accepted[56]
    output logic                 m_tlast,   // last
    output logic                 m_tuser,   // kind

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [SCORE_W-1:0]   cfg_data
);

    logic [1:0]                 state_reg, state_next;
    logic [POS_W-1:0]           class_pos_reg, class_pos_next;
    logic signed [SCORE_W-1:0]  best_value_reg, best_value_next;
    logic [CLASS_W-1:0]         best_class_reg, best_class_next;
    logic [CLASS_W-1:0]         prev_token_reg, prev_token_next;
    logic signed [TOTAL_W-1:0]  score_total_reg, score_total_next;
    logic [COUNT_W-1:0]         token_count_reg, token_count_next;
    logic [CLASS_W-1:0]         dict_size_reg;
    logic signed [SCORE_W-1:0]  min_conf_reg;

    logic [TOTAL_W-1:0]         div_quo_reg, div_quo_next;
    logic [COUNT_W-1:0]         div_rem_reg, div_rem_next;
    logic [DIV_CNT_W-1:0]       div_cnt_reg, div_cnt_next;
    logic                       div_neg_reg, div_neg_next;

    logic                       m_valid_reg, m_valid_next;
    logic                       m_kind_reg, m_kind_next;
    logic [CLASS_W-1:0]         m_token_reg, m_token_next;
    logic [SCORE_W-1:0]         m_tscore_reg, m_tscore_next;
    logic [SCORE_W-1:0]         m_conf_reg, m_conf_next;
    logic [COUNT_W-1:0]         m_cnt_reg, m_cnt_next;
    logic                       m_acc_reg, m_acc_next;
    logic                       m_last_reg, m_last_next;

    logic                       in_fire, out_free;
    logic signed [SCORE_W-1:0]  in_score;
    logic                       pos_ok, take, emit;
    logic [CLASS_W-1:0]         win_class;
    logic signed [SCORE_W-1:0]  win_score;
    logic [COUNT_W:0]           rem_sh;
    logic                       rem_ge;
    logic [COUNT_W:0]           rem_sub;
    logic signed [SCORE_W-1:0]  avg;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign in_score  = signed'(s_tdata[SCORE_W-1:0]);
    assign pos_ok    = class_pos_reg < POS_W'(MAX_CLASSES);
    assign take      = pos_ok && ((class_pos_reg == '0) || (in_score > best_value_reg));
    assign win_class = take ? class_pos_reg[CLASS_W-1:0] : best_class_reg;
    assign win_score = take ? in_score : best_value_reg;
    // class c is in the dictionary when c - 1 < dict_size, i.e. c <= dict_size
    assign emit      = s_tlast && (win_class != prev_token_reg) && (win_class != '0)
                       && (win_class <= dict_size_reg)
                       && (token_count_reg < COUNT_W'(MAX_STEPS));

    // Restoring divider step on magnitudes
    assign rem_sh  = {div_rem_reg, div_quo_reg[TOTAL_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, token_count_reg};
    assign rem_sub = rem_sh - {1'b0, token_count_reg};
    assign avg     = (token_count_reg == '0) ? '0 :
                     div_neg_reg ? signed'(-div_quo_reg[SCORE_W-1:0])
                                 : signed'(div_quo_reg[SCORE_W-1:0]);

    always_comb begin
        state_next       = state_reg;
        class_pos_next   = class_pos_reg;
        best_value_next  = best_value_reg;
        best_class_next  = best_class_reg;
        prev_token_next  = prev_token_reg;
        score_total_next = score_total_reg;
        token_count_next = token_count_reg;
        div_quo_next     = div_quo_reg;
        div_rem_next     = div_rem_reg;
        div_cnt_next     = div_cnt_reg;
        div_neg_next     = div_neg_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_kind_next      = m_kind_reg;
        m_token_next     = m_token_reg;
        m_tscore_next    = m_tscore_reg;
        m_conf_next      = m_conf_reg;
        m_cnt_next       = m_cnt_reg;
        m_acc_next       = m_acc_reg;
        m_last_next      = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (pos_ok) begin
                        class_pos_next = class_pos_reg + POS_W'(1);
                        if (take) begin
                            best_value_next = in_score;
                            best_class_next = class_pos_reg[CLASS_W-1:0];
                        end
                    end
                    if (s_tlast) begin
                        class_pos_next  = '0;
                        best_value_next = '0;
                        best_class_next = '0;
                        if (win_class != prev_token_reg) begin
                            prev_token_next = win_class;
                        end
                        if (emit) begin
                            score_total_next = score_total_reg +
                                {{(TOTAL_W-SCORE_W){win_score[SCORE_W-1]}}, win_score};
                            token_count_next = token_count_reg + COUNT_W'(1);
                            m_valid_next  = 1'b1;
                            m_kind_next   = KIND_TOKEN;
                            m_token_next  = win_class;
                            m_tscore_next = win_score;
                            m_conf_next   = '0;
                            m_cnt_next    = '0;
                            m_acc_next    = 1'b0;
                            m_last_next   = 1'b0;
                        end
                        if (s_tuser) begin
                            state_next = ST_LOAD;
                        end
                    end
                end
            end
            ST_LOAD: begin
                div_neg_next = score_total_reg[TOTAL_W-1];
                div_quo_next = score_total_reg[TOTAL_W-1] ? TOTAL_W'(-score_total_reg)
                                                          : TOTAL_W'(score_total_reg);
                div_rem_next = '0;
                div_cnt_next = '0;
                // nothing emitted: average is zero, skip the divide
                state_next   = (token_count_reg == '0) ? ST_VERDICT : ST_DIV;
            end
            ST_DIV: begin
                div_quo_next = {div_quo_reg[TOTAL_W-2:0], rem_ge};
                div_rem_next = rem_ge ? rem_sub[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(TOTAL_W - 1)) begin
                    state_next = ST_VERDICT;
                end
            end
            ST_VERDICT: begin
                if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_kind_next      = KIND_VERDICT;
                    m_token_next     = '0;
                    m_tscore_next    = '0;
                    m_conf_next      = avg;
                    m_cnt_next       = token_count_reg;
                    m_acc_next       = (token_count_reg != '0) && (avg >= min_conf_reg);
                    m_last_next      = 1'b1;
                    prev_token_next  = '0;
                    score_total_next = '0;
                    token_count_next = '0;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            class_pos_reg   <= '0;
            best_value_reg  <= '0;
            best_class_reg  <= '0;
            prev_token_reg  <= '0;
            score_total_reg <= '0;
            token_count_reg <= '0;
            m_valid_reg     <= 1'b0;
            dict_size_reg   <= DICT_SIZE_RST;
            min_conf_reg    <= signed'(MIN_CONF_RST);
        end else begin
            state_reg       <= state_next;
            class_pos_reg   <= class_pos_next;
            best_value_reg  <= best_value_next;
            best_class_reg  <= best_class_next;
            prev_token_reg  <= prev_token_next;
            score_total_reg <= score_total_next;
            token_count_reg <= token_count_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DICT_SIZE: dict_size_reg <= cfg_data[CLASS_W-1:0];
                    REG_MIN_CONF:  min_conf_reg  <= signed'(cfg_data);
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        div_quo_reg  <= div_quo_next;
        div_rem_reg  <= div_rem_next;
        div_cnt_reg  <= div_cnt_next;
        div_neg_reg  <= div_neg_next;
        m_kind_reg   <= m_kind_next;
        m_token_reg  <= m_token_next;
        m_tscore_reg <= m_tscore_next;
        m_conf_reg   <= m_conf_next;
        m_cnt_reg    <= m_cnt_next;
        m_acc_reg    <= m_acc_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(M_TDATA_W-M_USED_W){1'b0}}, m_acc_reg, m_cnt_reg, m_conf_reg,
                       m_tscore_reg, m_token_reg};

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (state_reg == ST_IDLE))
        else $error("input ready outside idle");

    a_kind_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == m_tlast))
        else $error("verdict and last disagree");

    a_token_nonblank: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_TOKEN)) |-> (m_tdata[CLASS_W-1:0] != '0))
        else $error("blank emitted as token");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        token_count_reg <= COUNT_W'(MAX_STEPS))
        else $error("token count past limit");

    a_div_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DIV) && (div_cnt_reg == DIV_CNT_W'(TOTAL_W - 1)))
        |=> (state_reg == ST_VERDICT))
        else $error("divider did not finish");

endmodule

[tb/ctc_decode_checker.sv]
`timescale 1ns / 100ps

module ctc_decode_checker
    import ctcgd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    input  logic                 s_tuser,

    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tlast,
    input  logic                 m_tuser,

    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [SCORE_W-1:0]   cfg_data,

    output int                   mismatches,
    output int                   outstanding
);

    typedef struct packed {
        logic                      kind;
        logic [CLASS_W-1:0]        token;
        logic [SCORE_W-1:0]        tscore;
        logic [SCORE_W-1:0]        conf;
        logic [COUNT_W-1:0]        cnt;
        logic                      acc;
        logic                      closes;
    } decode_result_t;

    decode_result_t expected_results[$];

    logic [CLASS_W-1:0]        dict_size;
    logic signed [SCORE_W-1:0] min_conf;

    int                        class_pos;
    logic signed [SCORE_W-1:0] best_score;
    logic [CLASS_W-1:0]        best_class;
    logic [CLASS_W-1:0]        prev_token;
    int                        score_sum;
    int                        token_cnt;

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic queue_result(input decode_result_t r);
        expected_results.insert(expected_results.size(), r);
    endtask

    // argmax over the timestep, then CTC collapse and the sequence verdict
    task automatic predict_decode(input logic signed [SCORE_W-1:0] score,
                                  input logic last_class, input logic last_step);
        decode_result_t            r;
        logic [CLASS_W-1:0]        winner;
        logic signed [SCORE_W-1:0] win_score;
        int                        avg;
        if (class_pos < MAX_CLASSES) begin
            if (class_pos == 0 || score > best_score) begin
                best_score = score;
                best_class = class_pos[CLASS_W-1:0];
            end
            class_pos++;
        end
        if (last_class) begin
            winner     = best_class;
            win_score  = best_score;
            class_pos  = 0;
            best_score = '0;
            best_class = '0;
            if (winner != prev_token) begin
                // previous class tracks even out-of-dictionary winners
                prev_token = winner;
                if (winner != 0 && int'(winner) - 1 < int'(dict_size)
                        && token_cnt < MAX_STEPS) begin
                    score_sum += win_score;
                    token_cnt++;
                    r        = '0;
                    r.kind   = KIND_TOKEN;
                    r.token  = winner;
                    r.tscore = win_score;
                    queue_result(r);
                end
            end
            if (last_step) begin
                avg      = (token_cnt != 0) ? score_sum / token_cnt : 0;
                r        = '0;
                r.kind   = KIND_VERDICT;
                r.conf   = avg[SCORE_W-1:0];
                r.cnt    = token_cnt[COUNT_W-1:0];
                r.acc    = (token_cnt != 0) && (avg >= min_conf);
                r.closes = 1'b1;
                queue_result(r);
                prev_token = '0;
                score_sum  = 0;
                token_cnt  = 0;
            end
        end
    endtask

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v !== got_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
        end
    endtask

    always @(posedge aclk) begin : monitor
        decode_result_t want;
        if (!aresetn) begin
            dict_size  = DICT_SIZE_RST;
            min_conf   = MIN_CONF_RST;
            class_pos  = 0;
            best_score = '0;
            best_class = '0;
            prev_token = '0;
            score_sum  = 0;
            token_cnt  = 0;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_DICT_SIZE) begin
                    dict_size = cfg_data[CLASS_W-1:0];
                end else begin
                    min_conf = cfg_data;
                end
            end
            if (s_tvalid && s_tready) begin
                predict_decode(s_tdata, s_tlast, s_tuser);
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected transaction, expected none, got tdata %h",
                             $time, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", want.kind, m_tuser);
                    check_field("token", want.token, m_tdata[TOKEN_LSB +: CLASS_W]);
                    check_field("token_score", $signed(want.tscore),
                                $signed(m_tdata[TSCORE_LSB +: SCORE_W]));
                    check_field("confidence", $signed(want.conf),
                                $signed(m_tdata[CONF_LSB +: SCORE_W]));
                    check_field("emitted_count", want.cnt, m_tdata[CNT_LSB +: COUNT_W]);
                    check_field("accepted", want.acc, m_tdata[ACC_BIT]);
                    check_field("last", want.closes, m_tlast);
                end
            end
        end
        outstanding = expected_results.size();
    end

endmodule

[tb/tb_ctc_greedy_token_decoder.sv]
`timescale 1ns / 100ps

module tb_ctc_greedy_token_decoder;
    import ctcgd_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;

    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 s_tuser = 1'b0;

    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_index = REG_DICT_SIZE;
    logic [SCORE_W-1:0]   cfg_data = '0;

    int                   mismatches;
    int                   outstanding;

    int                   burst_left = 0;
    bit                   gaps_on = 1'b1;
    int                   items_sent = 0;
    bit                   rx_hold = 1'b0;
    int                   rx_tick = 0;
    int                   rx_mode = 0;

    ctc_greedy_token_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ctc_decode_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // receiver: random stall patterns that change over time, long hold on request
    initial begin
        forever begin
            @(negedge aclk);
            rx_tick++;
            if (rx_hold) begin
                m_tready <= 1'b0;
                repeat (600) @(negedge aclk);
                rx_hold = 1'b0;
            end else begin
                if (rx_tick % 50 == 0) rx_mode = $urandom_range(0, 3);
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= $urandom_range(0, 1);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (rx_tick % 5 != 0);
                endcase
            end
        end
    end

    initial begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_score(input logic [15:0] sc, input logic lc, input logic ls);
        if (burst_left <= 0) begin
            if (gaps_on) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sc;
        s_tlast  <= lc;
        s_tuser  <= ls;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        burst_left--;
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        wait (outstanding == 0);
        // a token-only timestep may still be in flight; allow the verdict latency
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic load_config(input logic [15:0] dict, input logic [15:0] thr);
        drain();
        write_reg(REG_DICT_SIZE, dict);
        write_reg(REG_MIN_CONF, thr);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_score(input logic [15:0] tie);
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2, 3: return tie;
            4, 5: return 16'($urandom_range(0, 16383));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_sequence(input int max_steps);
        int          steps;
        int          ncls;
        logic [15:0] tie;
        logic        lc;
        logic        ls;
        steps   = $urandom_range(1, max_steps);
        gaps_on = ($urandom_range(0, 3) != 0);
        for (int t = 0; t < steps; t++) begin
            // few classes keep repeated winners common
            ncls = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
            tie  = $urandom;
            for (int c = 0; c < ncls; c++) begin
                lc = (c == ncls - 1);
                ls = lc ? (t == steps - 1) : ($urandom_range(0, 15) == 0);
                send_score(pick_score(tie), lc, ls);
            end
        end
    endtask

    initial begin
        int          phase_start;
        int          ncls;
        logic [15:0] sc;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // tie on blank, repeat collapse, blank between repeats, stray last_step
        send_score(16'h8000, 1'b0, 1'b0);
        send_score(16'h8000, 1'b1, 1'b0);
        send_score(16'd100, 1'b0, 1'b0);
        send_score(16'h7fff, 1'b0, 1'b0);
        send_score(16'h7fff, 1'b1, 1'b0);
        send_score(16'd5, 1'b0, 1'b0);
        send_score(16'd9, 1'b1, 1'b0);
        send_score(16'd0, 1'b1, 1'b0);
        send_score(-16'sd5, 1'b0, 1'b1);
        send_score(-16'sd3, 1'b1, 1'b1);
        // empty sequence
        send_score(16'd7, 1'b1, 1'b1);
        // negative average truncates toward zero
        send_score(16'h8000, 1'b0, 1'b0);
        send_score(-16'sd3, 1'b1, 1'b0);
        send_score(16'h8000, 1'b0, 1'b0);
        send_score(-16'sd100, 1'b0, 1'b0);
        send_score(-16'sd4, 1'b1, 1'b1);
        drain();

        // token count saturation, with the receiver held off to back up the block;
        // winners alternate between class 1 and class 2
        rx_hold = 1'b1;
        for (int t = 0; t < MAX_STEPS + 2; t++) begin
            ncls = 2 + t % 2;
            for (int c = 0; c < ncls; c++) begin
                if (c == ncls - 1) sc = 16'($urandom_range(16384, 32767));
                else sc = 16'($urandom_range(0, 16383));
                send_score(sc, c == ncls - 1, c == ncls - 1 && t == MAX_STEPS + 1);
            end
        end
        drain();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: load_config(16'd0, 16'h8000);
                1: load_config(16'd1, 16'h7fff);
                2: load_config(16'd3, 16'd0);
                3: load_config(16'h7fff, 16'($urandom));
                4: load_config(16'($urandom), 16'h8000);
                default: load_config(16'd2, 16'($urandom));
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < 8) run_sequence(4);
        end

        drain();
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
